// ===== design/sapf_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the slot allocator.
package sapf_pkg;

	localparam int SLOTS      = 64;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int HANDLE_W   = 32;
	localparam int GRP_SIZE   = 8;
	localparam int NGRP       = SLOTS / GRP_SIZE;
	localparam int GRP_W      = $clog2(NGRP);
	localparam int LOW_W      = $clog2(GRP_SIZE);
	localparam int SADDR_W    = SLOT_W + 1;
	localparam int EXT_W      = 9;
	localparam int PC_MAX     = 127;

	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_RELEASE = 3'd1,
		OP_MARK    = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_SCAN,
		S_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_rdy;
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic scan_op;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

// ===== design/sapf_if.sv =====
// Request and response channel interfaces of the slot allocator.
interface sapf_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] handle;
	logic [7:0]  slot;

	modport source(output valid, operation, handle, slot, input ready);
	modport sink(input valid, operation, handle, slot, output ready);
endinterface

interface sapf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] slot_index;
	logic       was_pending;
	logic       is_valid;
	logic [6:0] pending_count;

	modport source(output valid, status, slot_index, was_pending, is_valid, pending_count,
		input ready);
	modport sink(input valid, status, slot_index, was_pending, is_valid, pending_count,
		output ready);
endinterface

// ===== design/slot_allocator_with_pending_flags_unit.sv =====
// Top level of the slot allocator with pending flags.
//
// A table of SLOTS owner handles with a used bitmap and per-slot pending flags; one result beat
// per request beat. Allocate, mark, clear and unknown codes pass from acceptance to the result
// register through accept, a wait state for the registered free-slot tree and commit. Release
// and query walk the owner table through its single read port, one entry per cycle, stopping
// at the lowest matching used slot; a miss walks every entry up to the last slot of the table.
// One request is in work at a time; the next request is accepted as soon as the previous one
// has been committed to the output register, even while that result still waits to be taken.
// The owner table is not cleared at reset: entries of free slots are never compared.
module slot_allocator_with_pending_flags_unit import sapf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sapf_in_if.sink    in_ch,
	sapf_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	sapf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sapf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ===== design/sapf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sapf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/sapf_ctrl.sv =====
// Sequencing state machine of the slot allocator.
module sapf_ctrl import sapf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.scan_op ? S_SCAN : S_WAIT;
				end
			end
			S_WAIT: begin
				// let the free-slot tree settle on the current bitmap
				state_nxt = S_FINISH;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

// ===== design/sapf_dp.sv =====
// Datapath: slot bitmaps, pending flags, owner table walk, free-slot tree and result register.
module sapf_dp import sapf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	sapf_in_if.sink      in_ch,
	sapf_out_if.source   out_ch
);

	// Item registers
	op_t                 op_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [7:0]          slot_q;

	// Slot state
	logic [SLOTS-1:0]    used_q;
	logic [SLOTS-1:0]    pend_q;
	logic [CNT_W-1:0]    total_q;

	// Owner table walk
	logic [SADDR_W-1:0]  scan_addr_q;
	logic                cmp_vld_s1;
	logic [SLOT_W-1:0]   cmp_idx_s1;
	logic [HANDLE_W-1:0] rd_data;
	logic                match;
	logic                hit_q;
	logic [SLOT_W-1:0]   hit_idx_q;

	// Free-slot tree
	logic                grp_any_s1 [NGRP];
	logic [LOW_W-1:0]    grp_low_s1 [NGRP];
	logic                grp_any    [NGRP];
	logic [LOW_W-1:0]    grp_low    [NGRP];
	logic                free_any;
	logic [SLOT_W-1:0]   free_idx;

	// Finish step
	status_t             res_status;
	logic [SLOT_W-1:0]   res_idx;
	logic                res_was;
	logic                res_valid;
	logic [SLOT_W-1:0]   tgt_idx;
	logic                used_set;
	logic                used_clr;
	logic                pend_set;
	logic                pend_clr;
	logic                ram_we;
	logic                in_range;
	logic [SLOT_W-1:0]   slot_idx;
	logic                inc;
	logic                dec;
	logic [CNT_W-1:0]    total_nxt;
	logic [7:0]          idx_ext;
	logic [EXT_W-1:0]    tot_ext;

	// Result register
	logic                out_valid_q;
	status_t             status_q;
	logic [5:0]          slot_index_q;
	logic                was_pending_q;
	logic                is_valid_q;
	logic [6:0]          pending_count_q;

	assign in_ch.ready   = cmd.in_rdy;
	assign sts.in_valid  = in_ch.valid;
	assign sts.scan_op   = (in_ch.operation == OP_RELEASE) || (in_ch.operation == OP_QUERY);
	assign sts.out_free  = !out_valid_q || out_ch.ready;

	// Capture the beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(in_ch.operation);
			handle_q <= in_ch.handle;
			slot_q   <= in_ch.slot;
		end
	end

	// Owner table
	sapf_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (SLOTS)
	) u_owner (
		.clk   (clk),
		.we    (cmd.commit && ram_we),
		.waddr (tgt_idx),
		.wdata (handle_q),
		.raddr (scan_addr_q[SLOT_W-1:0]),
		.rdata (rd_data)
	);

	// Walk the table one entry per cycle, compare in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan && (scan_addr_q < SADDR_W'(SLOTS));
			if (cmd.load) begin
				scan_addr_q <= '0;
				hit_q       <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_addr_q < SADDR_W'(SLOTS)) begin
					scan_addr_q <= scan_addr_q + SADDR_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_addr_q[SLOT_W-1:0];
		if (cmd.scan && match) begin
			hit_idx_q <= cmp_idx_s1;
		end
	end

	assign match         = cmp_vld_s1 && used_q[cmp_idx_s1] && (rd_data == handle_q);
	assign sts.scan_done = match || (cmp_vld_s1 && (cmp_idx_s1 == SLOT_W'(SLOTS - 1)));

	// First level of the free-slot tree: lowest free slot in each group of eight
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = 1'b0;
			grp_low[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (!used_q[g*GRP_SIZE + b]) begin
					grp_any[g] = 1'b1;
					grp_low[g] = LOW_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_s1[g] <= grp_any[g];
			grp_low_s1[g] <= grp_low[g];
		end
	end

	// Second level: lowest group with a free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				free_any = 1'b1;
				free_idx = {GRP_W'(g), grp_low_s1[g]};
			end
		end
	end

	assign in_range = ({1'b0, slot_q} < EXT_W'(SLOTS));
	assign slot_idx = slot_q[SLOT_W-1:0];

	// Decode the operation into slot updates and result fields
	always_comb begin
		res_status = ST_OK;
		res_idx    = '0;
		res_was    = 1'b0;
		res_valid  = 1'b0;
		tgt_idx    = '0;
		used_set   = 1'b0;
		used_clr   = 1'b0;
		pend_set   = 1'b0;
		pend_clr   = 1'b0;
		ram_we     = 1'b0;
		unique case (op_q)
			OP_ALLOC: begin
				if (free_any) begin
					tgt_idx  = free_idx;
					res_idx  = free_idx;
					used_set = 1'b1;
					pend_clr = 1'b1;
					ram_we   = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_RELEASE: begin
				if (hit_q) begin
					tgt_idx  = hit_idx_q;
					res_idx  = hit_idx_q;
					used_clr = 1'b1;
					pend_clr = 1'b1;
				end else begin
					res_status = ST_NOTFOUND;
				end
			end
			OP_MARK: begin
				if (in_range) begin
					tgt_idx  = slot_idx;
					pend_set = 1'b1;
				end else begin
					res_status = ST_RANGE;
				end
			end
			OP_CLEAR: begin
				if (in_range) begin
					tgt_idx  = slot_idx;
					pend_clr = 1'b1;
					res_was  = pend_q[slot_idx];
				end else begin
					res_status = ST_RANGE;
				end
			end
			OP_QUERY: begin
				res_valid = hit_q;
			end
			default: begin
			end
		endcase
	end

	assign inc       = pend_set && !pend_q[tgt_idx];
	assign dec       = pend_clr && pend_q[tgt_idx];
	assign total_nxt = total_q + CNT_W'(inc) - CNT_W'(dec);
	assign idx_ext   = 8'(res_idx);
	assign tot_ext   = EXT_W'(total_nxt);

	// Apply the step to the bitmaps and the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			pend_q  <= '0;
			total_q <= '0;
		end else if (cmd.commit) begin
			if (used_set) begin
				used_q[tgt_idx] <= 1'b1;
			end else if (used_clr) begin
				used_q[tgt_idx] <= 1'b0;
			end
			if (pend_set) begin
				pend_q[tgt_idx] <= 1'b1;
			end else if (pend_clr) begin
				pend_q[tgt_idx] <= 1'b0;
			end
			total_q <= total_nxt;
		end
	end

	// Result register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q        <= res_status;
			slot_index_q    <= idx_ext[5:0];
			was_pending_q   <= res_was;
			is_valid_q      <= res_valid;
			pending_count_q <= (tot_ext > EXT_W'(PC_MAX)) ? 7'(PC_MAX) : tot_ext[6:0];
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.slot_index    = slot_index_q;
	assign out_ch.was_pending   = was_pending_q;
	assign out_ch.is_valid      = is_valid_q;
	assign out_ch.pending_count = pending_count_q;

	// The counter tracks the flags exactly
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == CNT_W'($countones(pend_q)))
		else $error("pending total differs from number of set flags");

	// A release frees a slot that is really in use
	a_release_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_RELEASE) && hit_q |-> used_q[hit_idx_q])
		else $error("release hit points at a free slot");

	// An allocation lands on a free slot
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_ALLOC) && free_any |-> !used_q[free_idx])
		else $error("allocation picked a used slot");

	// A result is only written into an empty or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ch.ready)
		else $error("result register overwritten before it was taken");

endmodule
